[design/fractional_key_midpoint_unit_assert.svh]
// Assertion macros for the fractional key midpoint unit.
`ifndef FRACTIONAL_KEY_MIDPOINT_UNIT_ASSERT_SVH
`define FRACTIONAL_KEY_MIDPOINT_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Clocked implication check, quiet during reset.
`define FKM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never hold.
`define FKM_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define FKM_ASSERT(lbl, prop, msg)
`define FKM_NEVER(lbl, cond, msg)
`endif
`endif

[design/fkm_pkg.sv]
package fkm_pkg;
	localparam int MAX_KEY_DIGITS = 20;
	localparam int IDX_W = $clog2(MAX_KEY_DIGITS);
	localparam int LEN_W = $clog2(MAX_KEY_DIGITS + 2);
	localparam int DIGIT_W = 6;
	localparam int SIG_LIMIT = 10;
	localparam logic [63:0] OFFSET_MASK = 64'h0FFF_FFFF_FFFF_FFFF;
	localparam int GAP_W = 60;
	localparam int MOD_W = 61;
	localparam int IN_DATA_W = 112;
	localparam int OUT_DATA_W = 8;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FIT   = 2'd1,
		ST_TOO_LONG = 2'd2
	} status_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mod_stat_t;
endpackage

[design/fkm_mod.sv]
module fkm_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [63:0]                dividend,
	input  logic [fkm_pkg::MOD_W-1:0]  divisor,
	output logic [fkm_pkg::MOD_W-1:0]  remainder,
	output fkm_pkg::mod_stat_t         stat
);
	import fkm_pkg::*;

	logic [63:0]      num_q;
	logic [MOD_W-1:0] den_q;
	logic [MOD_W-1:0] rem_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [MOD_W:0]   shifted;
	logic [MOD_W:0]   trial;

	// shift one dividend bit in, subtract when it fits
	assign shifted = {rem_q, num_q[63]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], 1'b0};
			if (!trial[MOD_W])
				rem_q <= trial[MOD_W-1:0];
			else
				rem_q <= shifted[MOD_W-1:0];
		end
	end

	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

[design/fractional_key_midpoint_unit.sv]
// Fractional key midpoint unit.
// Input stream: one request per key position, most significant first. tdata holds
// left_digit, right_digit, item_count and random_value; tuser holds the present
// flags; tlast marks the final position and starts the key search.
// After the final position the unit is busy: a multiply step for the needed
// count, then for each key width tried a setup step, a digit-serial
// increment/decrement/subtract pass, a pass to collect the gap, a check and,
// when the gap is small yet covers the need with room to spare, the
// bit-serial modulo unit. The chosen key then gets a digit-serial offset
// addition and one emit step per digit. Input is held off (tready low)
// from the final position until the last result digit is loaded.
// Output stream: tdata holds key_digit, tuser the status, tlast the final digit.
// A result sits in an output register; a stalled receiver holds it and the
// unit waits for the next load. Errors give one result with tlast set.
// Config: cfg_data writes collision_factor (reset 1) whenever cfg_valid is high.
// Reset clears the position count, key lengths and handshake state; digit
// stores hold stale data that is never read.
module fractional_key_midpoint_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [31:0]                    cfg_data,      // collision_factor
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// left_digit[5:0], right_digit[11:6], item_count[43:12], random_value[107:44]
	input  logic [fkm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [1:0]                     s_axis_tuser,  // left_present, right_present
	input  logic                           s_axis_tlast,  // last_position
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [fkm_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // key_digit[5:0]
	output logic [1:0]                     m_axis_tuser,  // status
	output logic                           m_axis_tlast   // last_digit
);
	import fkm_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_MUL   = 10'b00_0000_0010,
		S_INIT  = 10'b00_0000_0100,
		S_PASSA = 10'b00_0000_1000,
		S_PASSB = 10'b00_0001_0000,
		S_CHECK = 10'b00_0010_0000,
		S_MOD   = 10'b00_0100_0000,
		S_ADD   = 10'b00_1000_0000,
		S_EMIT  = 10'b01_0000_0000,
		S_ERR   = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	logic [DIGIT_W-1:0] left_mem_q  [MAX_KEY_DIGITS];
	logic [DIGIT_W-1:0] right_mem_q [MAX_KEY_DIGITS];
	logic [DIGIT_W-1:0] key_mem_q   [MAX_KEY_DIGITS];
	logic [DIGIT_W-1:0] gap_mem_q   [MAX_KEY_DIGITS];

	logic [31:0]      cf_q;
	logic [LEN_W-1:0] wl_q, wr_q, pos_q, w_q;
	logic             too_long_q;
	logic [31:0]      cnt_q;
	logic [63:0]      rnd_q;
	logic [63:0]      need_q;
	logic [IDX_W-1:0] idx_q;
	logic             lcy_q, rbw_q, gbw_q;
	logic             found_q, big_q;
	logic [GAP_W-1:0] gval_q;
	logic [63:0]      off_q;
	logic             acy_q;
	status_t          err_q;

	logic               ovalid_q, olast_q;
	logic [DIGIT_W-1:0] odigit_q;
	status_t            ostatus_q;

	// input field split
	logic [DIGIT_W-1:0] in_ld, in_rd;
	logic               in_lp, in_rp;
	assign in_ld = s_axis_tdata[5:0];
	assign in_rd = s_axis_tdata[11:6];
	assign in_lp = s_axis_tuser[0];
	assign in_rp = s_axis_tuser[1];

	logic in_acc, pos_room, too_long_n;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign pos_room      = (pos_q < LEN_W'(MAX_KEY_DIGITS));
	assign too_long_n    = too_long_q || (!pos_room && (in_lp || in_rp));

	assign cfg_ready = 1'b1;

	// needed count
	logic [31:0] cnt_eff;
	logic [63:0] prod;
	assign cnt_eff = (cnt_q == 32'd0) ? 32'd1 : cnt_q;
	assign prod    = 64'(cnt_eff) * 64'(cf_q);

	// digit-serial bound adjust and gap subtract
	logic [DIGIT_W-1:0] ld, rd_raw, rw, cur_key, cur_gap;
	logic [DIGIT_W:0]   ls, diff, asum;
	logic               rbw_n, passa_fail;
	assign cur_key = key_mem_q[idx_q];
	assign cur_gap = gap_mem_q[idx_q];
	assign ld      = (LEN_W'(idx_q) < wl_q) ? left_mem_q[idx_q] : '0;
	assign ls      = {1'b0, ld} + 7'(lcy_q);
	assign rd_raw  = (LEN_W'(idx_q) < wr_q) ? right_mem_q[idx_q] : '0;
	assign rw      = (wr_q == '0) ? 6'd63 : (rd_raw - 6'(rbw_q));
	assign rbw_n   = rbw_q && (rd_raw == '0);
	assign diff    = {1'b0, rw} - {1'b0, ls[DIGIT_W-1:0]} - 7'(gbw_q);
	assign passa_fail = ls[DIGIT_W] || rbw_n || diff[DIGIT_W];
	assign asum    = {1'b0, cur_key} + {1'b0, off_q[5:0]} + 7'(acy_q);

	// gap check
	logic [63:0] gp1, range_v;
	assign gp1     = 64'(gval_q) + 64'd1;
	assign range_v = gp1 - need_q;

	logic            mod_start;
	logic [MOD_W-1:0] mod_rem;
	mod_stat_t       mod_stat;
	assign mod_start = (state_q == S_CHECK) && !big_q && !(gp1 < need_q) &&
		(range_v != 64'd0);

	fkm_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (rnd_q),
		.divisor   (MOD_W'(range_v + 64'd1)),
		.remainder (mod_rem),
		.stat      (mod_stat)
	);

	logic out_load, out_push, emit_last;
	assign out_load  = !ovalid_q || m_axis_tready;
	assign out_push  = out_load && (state_q inside {S_EMIT, S_ERR});
	assign emit_last = (LEN_W'(idx_q) == (w_q - LEN_W'(1)));

	// store digits and work arrays
	always_ff @(posedge clk) begin
		if (in_acc && pos_room) begin
			left_mem_q[pos_q[IDX_W-1:0]]  <= in_lp ? in_ld : '0;
			right_mem_q[pos_q[IDX_W-1:0]] <= in_rp ? in_rd : '0;
		end
		if (state_q == S_PASSA) begin
			key_mem_q[idx_q] <= ls[DIGIT_W-1:0];
			gap_mem_q[idx_q] <= diff[DIGIT_W-1:0];
		end else if (state_q == S_ADD) begin
			key_mem_q[idx_q] <= asum[DIGIT_W-1:0];
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cf_q       <= 32'd1;
			wl_q       <= '0;
			wr_q       <= '0;
			pos_q      <= '0;
			too_long_q <= 1'b0;
			ovalid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				cf_q <= cfg_data;
			if (m_axis_tready && !out_push)
				ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (pos_room) begin
							if (in_lp) wl_q <= pos_q + LEN_W'(1);
							if (in_rp) wr_q <= pos_q + LEN_W'(1);
							pos_q <= pos_q + LEN_W'(1);
						end
						too_long_q <= too_long_n;
						cnt_q <= s_axis_tdata[43:12];
						rnd_q <= s_axis_tdata[107:44];
						if (s_axis_tlast) begin
							if (too_long_n) begin
								err_q   <= ST_TOO_LONG;
								state_q <= S_ERR;
							end else begin
								state_q <= S_MUL;
							end
						end
					end
				end
				S_MUL: begin
					need_q  <= (prod == 64'd0) ? 64'd1 : prod;
					w_q     <= (wl_q > wr_q) ? wl_q : ((wr_q == '0) ? LEN_W'(1) : wr_q);
					state_q <= S_INIT;
				end
				S_INIT: begin
					if (w_q > LEN_W'(MAX_KEY_DIGITS)) begin
						err_q   <= ST_NO_FIT;
						state_q <= S_ERR;
					end else begin
						idx_q   <= IDX_W'(w_q - LEN_W'(1));
						lcy_q   <= (wl_q >= w_q);
						rbw_q   <= (wr_q != '0);
						gbw_q   <= 1'b0;
						state_q <= S_PASSA;
					end
				end
				S_PASSA: begin
					lcy_q <= ls[DIGIT_W];
					rbw_q <= rbw_n;
					gbw_q <= diff[DIGIT_W];
					if (idx_q == '0) begin
						if (passa_fail) begin
							w_q     <= w_q + LEN_W'(1);
							state_q <= S_INIT;
						end else begin
							found_q <= 1'b0;
							big_q   <= 1'b0;
							gval_q  <= '0;
							state_q <= S_PASSB;
						end
					end else begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
				S_PASSB: begin
					gval_q <= {gval_q[GAP_W-DIGIT_W-1:0], cur_gap};
					if (!found_q && cur_gap != '0) begin
						found_q <= 1'b1;
						big_q   <= ((w_q - LEN_W'(idx_q)) > LEN_W'(SIG_LIMIT));
					end
					if (emit_last) begin
						state_q <= S_CHECK;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_CHECK: begin
					idx_q <= IDX_W'(w_q - LEN_W'(1));
					acy_q <= 1'b0;
					if (big_q) begin
						off_q   <= rnd_q & OFFSET_MASK;
						state_q <= S_ADD;
					end else if (gp1 < need_q) begin
						w_q     <= w_q + LEN_W'(1);
						state_q <= S_INIT;
					end else if (range_v == 64'd0) begin
						off_q   <= '0;
						state_q <= S_ADD;
					end else begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_stat.done) begin
						off_q   <= 64'(mod_rem);
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					acy_q <= asum[DIGIT_W];
					off_q <= {6'd0, off_q[63:6]};
					if (idx_q == '0) begin
						state_q <= S_EMIT;
					end else begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
				S_EMIT: begin
					if (out_load) begin
						ovalid_q  <= 1'b1;
						odigit_q  <= cur_key;
						olast_q   <= emit_last;
						ostatus_q <= ST_OK;
						if (emit_last) begin
							wl_q       <= '0;
							wr_q       <= '0;
							pos_q      <= '0;
							too_long_q <= 1'b0;
							state_q    <= S_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				S_ERR: begin
					if (out_load) begin
						ovalid_q   <= 1'b1;
						odigit_q   <= '0;
						olast_q    <= 1'b1;
						ostatus_q  <= err_q;
						wl_q       <= '0;
						wr_q       <= '0;
						pos_q      <= '0;
						too_long_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = OUT_DATA_W'(odigit_q);
	assign m_axis_tuser  = ostatus_q;
	assign m_axis_tlast  = olast_q;

`include "fractional_key_midpoint_unit_assert.svh"

	`FKM_ASSERT(a_mod_done_in_mod, mod_stat.done |-> (state_q == S_MOD), "modulo done out of state")
	`FKM_NEVER(a_mod_busy_in_mod, mod_stat.busy && (state_q != S_MOD), "modulo busy out of state")
	`FKM_ASSERT(a_err_is_last, (m_axis_tvalid && m_axis_tuser != ST_OK) |-> m_axis_tlast, "error not last")
	`FKM_NEVER(a_emit_width, (state_q == S_EMIT) && (w_q > LEN_W'(MAX_KEY_DIGITS)), "emit width overflow")
endmodule
